// File: sv/fcfr_pkg.sv
// ----------------------------------------------------------------------------
// fcfr_pkg
// Types, constants and the byte-wide CRC-32 update shared by the frame
// receiver's files.
// ----------------------------------------------------------------------------
package fcfr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 1024;
	localparam int unsigned HDR_BYTES       = 16;
	localparam logic [31:0] FRAME_MAGIC     = 32'h5354_4D31;
	localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

	// APB register map: two 32-bit registers at byte offsets 0 and 4.
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic REG_IMAGE_SIZE = 1'b0;
	localparam logic REG_IMAGE_CRC  = 1'b1;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [2:0] {
		RESP_ACK       = 3'd0,
		RESP_BAD_MAGIC = 3'd1,
		RESP_BAD_LEN   = 3'd2,
		RESP_CRC_FAIL  = 3'd3,
		RESP_SIZE_FAIL = 3'd4,
		RESP_END_SIZE  = 3'd5,
		RESP_END_CRC   = 3'd6,
		RESP_END_OK    = 3'd7
	} resp_t;

	typedef struct packed {
		logic [31:0] image_size;
		logic [31:0] image_crc;
	} cfg_t;

	// Reflected CRC-32, one byte: eight shift-and-reduce steps.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: sv/fcfr_apb_regs.sv
// ----------------------------------------------------------------------------
// fcfr_apb_regs
// APB register file holding the expected image size and image CRC.
// ----------------------------------------------------------------------------
module fcfr_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fcfr_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output fcfr_pkg::cfg_t                      cfg
);

	fcfr_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic           reg_sel;

	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				fcfr_pkg::REG_IMAGE_SIZE: cfg_q.image_size <= pwdata;
				fcfr_pkg::REG_IMAGE_CRC:  cfg_q.image_crc  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			fcfr_pkg::REG_IMAGE_SIZE: prdata = cfg_q.image_size;
			fcfr_pkg::REG_IMAGE_CRC:  prdata = cfg_q.image_crc;
			default:                  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: sv/firmware_chunk_frame_receiver.sv
// ----------------------------------------------------------------------------
// firmware_chunk_frame_receiver
// Firmware-update frame receiver with header checks and CRC-32 verification.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while no result waits to be taken:
// each byte is registered on acceptance and fully processed once no result
// waits, where the byte-wide CRC-32 update of the chunk and image checksums,
// the header field capture and the size compare share one stage. A response
// is registered in the result register as its frame's last item is processed.
// While that result waits to be taken, the input register still takes one
// more item, and then the input stalls until the result is taken. A start item
// enters data mode and clears the frame and image state; bytes outside data
// mode are dropped without a response. Frames are a 16-byte little-endian header
// (magic, sequence, length, reserved, chunk CRC) plus payload; a zero-length
// frame asks for the end-of-image verdict against the image_size and image_crc
// registers, which the user must write only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module firmware_chunk_frame_receiver #(
	parameter int unsigned MAX_PAYLOAD = fcfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcfr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            op,
	input  logic [7:0]                      data_byte,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [2:0]                      response,
	output logic [31:0]                     sequence_res,
	output logic                            leaves_data_mode
);

	localparam int unsigned POS_W   = $clog2(MAX_PAYLOAD + fcfr_pkg::HDR_BYTES + 1);
	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);
	localparam logic [POS_W-1:0] HDR_POS = POS_W'(fcfr_pkg::HDR_BYTES);

	fcfr_pkg::cfg_t cfg;

	fcfr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// Input register.
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// Receiver state.
	logic             mode_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      magic_q;
	logic [31:0]      seq_q;
	logic [15:0]      len_q;
	logic [31:0]      hcrc_q;
	logic [31:0]      chunk_q;
	logic [31:0]      pend_q;
	logic [31:0]      run_q;
	logic [31:0]      cnt_q;

	// Result register.
	logic             out_valid_q;
	fcfr_pkg::resp_t  resp_q;
	logic [31:0]      rseq_q;
	logic             leave_q;

	logic             proc;
	logic             can_proc;

	logic             n_mode;
	logic [POS_W-1:0] n_pos;
	logic [31:0]      n_magic;
	logic [31:0]      n_seq;
	logic [15:0]      n_len;
	logic [31:0]      n_hcrc;
	logic [31:0]      n_chunk;
	logic [31:0]      n_pend;
	logic [31:0]      n_run;
	logic [31:0]      n_cnt;

	logic             emit;
	fcfr_pkg::resp_t  r_resp;
	logic [31:0]      r_seq;
	logic             r_leave;

	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] frame_end;
	logic [31:0]      crc_chunk;
	logic [31:0]      crc_pend;
	logic [32:0]      size_sum;

	assign can_proc   = !out_valid_q || result_ready;
	assign proc       = valid_s1 && can_proc;
	assign item_ready = !valid_s1 || can_proc;

	assign pos_inc   = pos_q + POS_W'(1);
	assign frame_end = HDR_POS + POS_W'(len_q);
	assign crc_chunk = fcfr_pkg::crc_byte(chunk_q, byte_s1);
	assign crc_pend  = fcfr_pkg::crc_byte(pend_q, byte_s1);
	assign size_sum  = {1'b0, cnt_q} + {17'd0, len_q};

	always_comb begin
		n_mode  = mode_q;
		n_pos   = pos_q;
		n_magic = magic_q;
		n_seq   = seq_q;
		n_len   = len_q;
		n_hcrc  = hcrc_q;
		n_chunk = chunk_q;
		n_pend  = pend_q;
		n_run   = run_q;
		n_cnt   = cnt_q;
		emit    = 1'b0;
		r_resp  = fcfr_pkg::RESP_ACK;
		r_seq   = '0;
		r_leave = 1'b0;

		if (op_s1 == fcfr_pkg::OP_START) begin
			n_mode  = 1'b1;
			n_pos   = '0;
			n_magic = '0;
			n_seq   = '0;
			n_len   = '0;
			n_hcrc  = '0;
			n_chunk = fcfr_pkg::ALL_ONES;
			n_pend  = fcfr_pkg::ALL_ONES;
			n_run   = fcfr_pkg::ALL_ONES;
			n_cnt   = '0;
		end else if (mode_q) begin
			n_pos = pos_inc;
			if (pos_q < HDR_POS) begin
				// Header fields arrive little-endian and shift in from the top.
				case (pos_q[3:2])
					2'd0: n_magic = {byte_s1, magic_q[31:8]};
					2'd1: n_seq   = {byte_s1, seq_q[31:8]};
					2'd2: if (!pos_q[1]) n_len = {byte_s1, len_q[15:8]};
					2'd3: n_hcrc  = {byte_s1, hcrc_q[31:8]};
					default: ;
				endcase
				if (pos_inc == HDR_POS) begin
					if (magic_q != fcfr_pkg::FRAME_MAGIC) begin
						emit   = 1'b1;
						r_resp = fcfr_pkg::RESP_BAD_MAGIC;
					end else if (len_q > MAX_LEN) begin
						emit   = 1'b1;
						r_resp = fcfr_pkg::RESP_BAD_LEN;
					end else begin
						n_chunk = fcfr_pkg::ALL_ONES;
						n_pend  = run_q;
						if (len_q == 16'd0) begin
							emit  = 1'b1;
							r_seq = seq_q;
							if (cnt_q != cfg.image_size) begin
								r_resp = fcfr_pkg::RESP_END_SIZE;
							end else if (~run_q != cfg.image_crc) begin
								r_resp = fcfr_pkg::RESP_END_CRC;
							end else begin
								r_resp  = fcfr_pkg::RESP_END_OK;
								r_leave = 1'b1;
							end
						end
					end
				end
			end else begin
				n_chunk = crc_chunk;
				n_pend  = crc_pend;
				if (pos_inc == frame_end) begin
					emit  = 1'b1;
					r_seq = seq_q;
					if (~crc_chunk != hcrc_q) begin
						r_resp  = fcfr_pkg::RESP_CRC_FAIL;
						r_leave = 1'b1;
					end else begin
						// The image CRC takes the chunk even when the size overflows.
						n_run = crc_pend;
						if (size_sum > {1'b0, cfg.image_size}) begin
							r_resp = fcfr_pkg::RESP_SIZE_FAIL;
						end else begin
							n_cnt  = size_sum[31:0];
							r_resp = fcfr_pkg::RESP_ACK;
						end
					end
				end
			end
		end

		if (emit) begin
			n_pos = '0;
		end
		if (emit && r_leave) begin
			n_mode = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mode_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (proc) begin
				mode_q <= n_mode;
				pos_q  <= n_pos;
			end
			if (proc && emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
		if (proc) begin
			magic_q <= n_magic;
			seq_q   <= n_seq;
			len_q   <= n_len;
			hcrc_q  <= n_hcrc;
			chunk_q <= n_chunk;
			pend_q  <= n_pend;
			run_q   <= n_run;
			cnt_q   <= n_cnt;
		end
		if (proc && emit) begin
			resp_q  <= r_resp;
			rseq_q  <= r_seq;
			leave_q <= r_leave;
		end
	end

	assign result_valid     = out_valid_q;
	assign response         = resp_q;
	assign sequence_res     = rseq_q;
	assign leaves_data_mode = leave_q;

`ifndef SYNTH
	// Only a chunk CRC failure and a good end verdict return to control mode.
	a_leave_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (leaves_data_mode ==
			(resp_q == fcfr_pkg::RESP_CRC_FAIL || resp_q == fcfr_pkg::RESP_END_OK)))
		else $error("leaves_data_mode does not match the response code");

	// Header errors carry no sequence number.
	a_hdr_err_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (resp_q == fcfr_pkg::RESP_BAD_MAGIC ||
			resp_q == fcfr_pkg::RESP_BAD_LEN)) |-> (sequence_res == 32'd0))
		else $error("header error response with nonzero sequence");

	// Every response restarts frame parsing at the first header byte.
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && emit) |=> (pos_q == '0))
		else $error("byte position not cleared after a response");

	// Data mode is left only through a response that says so.
	a_mode_exit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(mode_q) |-> $past(proc && emit && r_leave))
		else $error("data mode left without a leaving response");
`endif

endmodule
